/* hdl/lsw_pkg.sv */
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared types and constants of the lattice sieve prime walk: field widths,
// microcode word layout and the status/control bundles between the sequencer
// and the datapath.
// ----------------------------------------------------------------------------
package lsw_pkg;

	localparam int I_BITS_DEF   = 13;
	localparam int L1_BITS_DEF  = 16;
	localparam int MAX_HITS_DEF = 63;

	localparam int POS_W   = 32;
	localparam int STEP_W  = 32;
	localparam int PRIME_W = 16;
	localparam int HPOS_W  = 16;
	localparam int OT_W    = 2;

	// microcode address width and program addresses
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_LOAD  = 3'd0;
	localparam logic [PC_W-1:0] PC_START = 3'd1;
	localparam logic [PC_W-1:0] PC_HALVE = 3'd2;
	localparam logic [PC_W-1:0] PC_TEST  = 3'd3;
	localparam logic [PC_W-1:0] PC_HIT   = 3'd4;
	localparam logic [PC_W-1:0] PC_FINAL = 3'd5;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_START,
		OP_HALVE,
		OP_HIT,
		OP_FINAL
	} op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_OT_ZERO,
		COND_WALK_END
	} cond_t;

	typedef struct packed {
		op_t             op;
		logic            wait_in;
		logic            wait_out;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic slot_free;
		logic ot_zero;
		logic walk_end;
	} status_t;

endpackage

/* hdl/lsw_prime_if.sv */
// ----------------------------------------------------------------------------
// lsw_prime_if
// Input channel: one factor-base prime per transaction.
// ----------------------------------------------------------------------------
interface lsw_prime_if
	import lsw_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [STEP_W-1:0]  first_step;
	logic [STEP_W-1:0]  second_step;
	logic [POS_W-1:0]   start_pos;
	logic [PRIME_W-1:0] prime_index;
	logic               end_of_batch;

	modport source (output valid, first_step, second_step, start_pos, prime_index,
		end_of_batch, input ready);
	modport sink (input valid, first_step, second_step, start_pos, prime_index,
		end_of_batch, output ready);
endinterface

/* hdl/lsw_hit_if.sv */
// ----------------------------------------------------------------------------
// lsw_hit_if
// Output channel: sieve hits followed by one final writeback transaction.
// ----------------------------------------------------------------------------
interface lsw_hit_if
	import lsw_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               hit_valid;
	logic [PRIME_W-1:0] hit_prime;
	logic [HPOS_W-1:0]  hit_pos;
	logic [POS_W-1:0]   next_pos;
	logic               odd_exception;
	logic               hit_overflow;
	logic               batch_done;
	logic               last;

	modport source (output valid, hit_valid, hit_prime, hit_pos, next_pos,
		odd_exception, hit_overflow, batch_done, last, input ready);
	modport sink (input valid, hit_valid, hit_prime, hit_pos, next_pos,
		odd_exception, hit_overflow, batch_done, last, output ready);
endinterface

/* hdl/lsw_cfg_if.sv */
// ----------------------------------------------------------------------------
// lsw_cfg_if
// Configuration write channel for the oddness type register.
// ----------------------------------------------------------------------------
interface lsw_cfg_if
	import lsw_pkg::*;
;
	logic            valid;
	logic            ready;
	logic [OT_W-1:0] oddness_type;

	modport source (output valid, oddness_type, input ready);
	modport sink (input valid, oddness_type, output ready);
endinterface

/* hdl/lattice_sieve_prime_walk_core.sv */
// ----------------------------------------------------------------------------
// lattice_sieve_prime_walk_core
// Franke-Kleinjung lattice walk of one factor-base prime over an L1 region.
// ----------------------------------------------------------------------------
// Channels: prime_ch takes one prime per transaction (two lattice steps, start
// position, index, end-of-batch mark). hit_ch returns one transaction per
// sieve hit, then one final writeback transaction with last set. cfg_ch
// writes the oddness type; write it only while the core is idle.
// Sequence: a microcoded sequencer handles one prime at a time. It loads the
// prime, derives its start (start, then halve) when the oddness type is
// nonzero, then loops on test, then emit and step for each hit, ends with a
// final test and the writeback, and only then takes the next prime. The step
// loop runs through the single position adder; hits are capped at MAX_HITS.
// Reset: clears the sequencer to its load step, empties the output register
// and sets the oddness type to 0.
// Stall: results sit in a one-deep output register; while it is full and
// hit_ch is not ready the sequencer holds its hit or writeback step.
// ----------------------------------------------------------------------------
module lattice_sieve_prime_walk_core
	import lsw_pkg::*;
#(
	parameter int I_BITS   = I_BITS_DEF,
	parameter int L1_BITS  = L1_BITS_DEF,
	parameter int MAX_HITS = MAX_HITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lsw_prime_if.sink prime_ch,
	lsw_hit_if.source hit_ch,
	lsw_cfg_if.sink   cfg_ch
);

	logic [OT_W-1:0] ot_q;
	ctrl_t           ctrl;
	status_t         status;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ot_q <= '0;
		end else if (cfg_ch.valid) begin
			ot_q <= cfg_ch.oddness_type;
		end
	end

	lsw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	lsw_dp #(
		.I_BITS   (I_BITS),
		.L1_BITS  (L1_BITS),
		.MAX_HITS (MAX_HITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ot       (ot_q),
		.ctrl     (ctrl),
		.status   (status),
		.prime_ch (prime_ch),
		.hit_ch   (hit_ch)
	);

endmodule

/* hdl/lsw_seq.sv */
// ----------------------------------------------------------------------------
// lsw_seq
// Microcode sequencer: program ROM, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module lsw_seq
	import lsw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucode_t          uw;
	logic            stall;
	logic            take;

	// program ROM
	always_comb begin
		case (pc_q)
			PC_LOAD:  uw = '{OP_LOAD,  1'b1, 1'b0, COND_OT_ZERO,  PC_TEST};
			PC_START: uw = '{OP_START, 1'b0, 1'b0, COND_NEXT,     PC_LOAD};
			PC_HALVE: uw = '{OP_HALVE, 1'b0, 1'b0, COND_NEXT,     PC_LOAD};
			PC_TEST:  uw = '{OP_NOP,   1'b0, 1'b0, COND_WALK_END, PC_FINAL};
			PC_HIT:   uw = '{OP_HIT,   1'b0, 1'b1, COND_ALWAYS,   PC_TEST};
			PC_FINAL: uw = '{OP_FINAL, 1'b0, 1'b1, COND_ALWAYS,   PC_LOAD};
			default:  uw = '{OP_NOP,   1'b0, 1'b0, COND_ALWAYS,   PC_LOAD};
		endcase
	end

	always_comb begin
		stall = (uw.wait_in && !status.in_valid) || (uw.wait_out && !status.slot_free);
		case (uw.cond)
			COND_NEXT:     take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_OT_ZERO:  take = status.ot_zero;
			COND_WALK_END: take = status.walk_end;
			default:       take = 1'b0;
		endcase
		if (stall) begin
			pc_next = pc_q;
		end else if (take) begin
			pc_next = uw.target;
		end else begin
			pc_next = pc_q + PC_W'(1);
		end
		ctrl.op   = uw.op;
		ctrl.fire = !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

/* hdl/lsw_dp.sv */
// ----------------------------------------------------------------------------
// lsw_dp
// Walk datapath: prime registers, start derivation, lattice step adder,
// hit counter and the output register.
// ----------------------------------------------------------------------------
module lsw_dp
	import lsw_pkg::*;
#(
	parameter int I_BITS   = I_BITS_DEF,
	parameter int L1_BITS  = L1_BITS_DEF,
	parameter int MAX_HITS = MAX_HITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [OT_W-1:0] ot,
	input  ctrl_t           ctrl,
	output status_t         status,
	lsw_prime_if.sink       prime_ch,
	lsw_hit_if.source       hit_ch
);

	localparam int CNT_W = $clog2(MAX_HITS + 1);
	localparam int LO_W  = I_BITS - 1;
	localparam logic [POS_W-1:0]  NI_W     = POS_W'(1) << (I_BITS - 1);
	localparam logic [POS_W-1:0]  MASK_W   = NI_W | POS_W'(1);
	localparam logic [POS_W-1:0]  REGION_W = POS_W'(1) << L1_BITS;
	localparam logic [I_BITS-1:0] NI_I     = I_BITS'(1) << (I_BITS - 1);
	localparam logic [CNT_W-1:0]  MAX_C    = CNT_W'(MAX_HITS);

	logic [STEP_W-1:0]  s0_q, s1_q;
	logic [POS_W-1:0]   pos_q;
	logic [PRIME_W-1:0] prime_q;
	logic               eob_q;
	logic               exc_q;
	logic [I_BITS-1:0]  lim_a_q, lim_b_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic               o_hit_q;
	logic [PRIME_W-1:0] o_prime_q;
	logic [HPOS_W-1:0]  o_pos_q;
	logic [POS_W-1:0]   o_next_q;
	logic               o_exc_q, o_ovf_q, o_done_q, o_last_q;

	logic [POS_W-1:0]  tester;
	logic              match0, match1, lo_le, lo_eq;
	logic [POS_W-1:0]  start_val;
	logic              start_exc;
	logic [POS_W-1:0]  half_add;
	logic              below;
	logic [I_BITS-1:0] i_cur;
	logic [POS_W-1:0]  add0, add1;
	logic              slot_free;

	assign below     = (pos_q < REGION_W);
	assign slot_free = !out_valid_q || hit_ch.ready;

	always_comb begin
		status.in_valid  = prime_ch.valid;
		status.slot_free = slot_free;
		status.ot_zero   = (ot == OT_W'(0));
		status.walk_end  = !below || (cnt_q == MAX_C);
	end

	assign prime_ch.ready = (ctrl.op == OP_LOAD);

	// start case rules of the oddness sublattice
	always_comb begin
		tester    = (ot[1] ? NI_W : '0) | POS_W'(ot[0]);
		match0    = ((s0_q & MASK_W) == tester);
		match1    = ((s1_q & MASK_W) == (tester ^ NI_W));
		lo_le     = (s0_q[LO_W-1:0] <= s1_q[LO_W-1:0]);
		lo_eq     = (s0_q[LO_W-1:0] == s1_q[LO_W-1:0]);
		start_exc = 1'b0;
		if (match0) begin
			start_val = s0_q;
		end else if (match1) begin
			start_val = s1_q;
		end else if (lo_le && (s0_q <= s1_q)) begin
			start_val = lo_eq ? (s1_q - s0_q) : NI_W;
			start_exc = (ot != OT_W'(2));
		end else begin
			start_val = s0_q + s1_q;
		end
		half_add = ot[1] ? '0 : NI_W;
	end

	// choose first step, second step or both from the low i bits
	always_comb begin
		i_cur = {1'b0, pos_q[LO_W-1:0]};
		add0  = (i_cur < lim_b_q) ? s0_q : '0;
		add1  = (i_cur >= lim_a_q) ? s1_q : '0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (ctrl.op)
				OP_LOAD: begin
					s0_q    <= prime_ch.first_step;
					s1_q    <= prime_ch.second_step;
					pos_q   <= prime_ch.start_pos;
					prime_q <= prime_ch.prime_index;
					eob_q   <= prime_ch.end_of_batch;
					exc_q   <= 1'b0;
					cnt_q   <= '0;
					lim_a_q <= NI_I - {1'b0, prime_ch.first_step[LO_W-1:0]};
					lim_b_q <= NI_I - {1'b0, prime_ch.second_step[LO_W-1:0]};
				end
				OP_START: begin
					pos_q <= start_val;
					exc_q <= start_exc;
				end
				OP_HALVE: begin
					pos_q <= (pos_q + half_add) >> 1;
				end
				OP_HIT: begin
					pos_q <= pos_q + add0 + add1;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire && (ctrl.op == OP_HIT || ctrl.op == OP_FINAL)) begin
			out_valid_q <= 1'b1;
		end else if (hit_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.op == OP_HIT) begin
			o_hit_q   <= 1'b1;
			o_prime_q <= prime_q;
			o_pos_q   <= pos_q[HPOS_W-1:0];
			o_next_q  <= '0;
			o_exc_q   <= 1'b0;
			o_ovf_q   <= 1'b0;
			o_done_q  <= 1'b0;
			o_last_q  <= 1'b0;
		end else if (ctrl.fire && ctrl.op == OP_FINAL) begin
			// still inside the region here means the hit budget cut the walk
			o_hit_q   <= 1'b0;
			o_prime_q <= prime_q;
			o_pos_q   <= '0;
			o_next_q  <= pos_q - REGION_W;
			o_exc_q   <= exc_q;
			o_ovf_q   <= below;
			o_done_q  <= eob_q;
			o_last_q  <= 1'b1;
		end
	end

	assign hit_ch.valid         = out_valid_q;
	assign hit_ch.hit_valid     = o_hit_q;
	assign hit_ch.hit_prime     = o_prime_q;
	assign hit_ch.hit_pos       = o_pos_q;
	assign hit_ch.next_pos      = o_next_q;
	assign hit_ch.odd_exception = o_exc_q;
	assign hit_ch.hit_overflow  = o_ovf_q;
	assign hit_ch.batch_done    = o_done_q;
	assign hit_ch.last          = o_last_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks lattice_sieve_prime_walk_core against a behavioral walk predictor.
// A directed table covers the extremes, every start derivation rule and the
// hit cap. Eight phases of random primes follow, two per oddness type. Both
// channels idle at random, with one phase that never idles.
// ----------------------------------------------------------------------------
module testbench
	import lsw_pkg::*;
;

	localparam logic [31:0] NI       = 32'd1 << (I_BITS_DEF - 1);
	localparam logic [31:0] NI_MASK  = NI - 32'd1;
	localparam logic [31:0] ODD_MASK = NI | 32'd1;
	localparam logic [31:0] REGION   = 32'd1 << L1_BITS_DEF;

	localparam logic [OT_W-1:0] OT_INPUT = 2'd0;
	localparam logic [OT_W-1:0] OT_TYPE1 = 2'd1;
	localparam logic [OT_W-1:0] OT_TYPE2 = 2'd2;
	localparam logic [OT_W-1:0] OT_TYPE3 = 2'd3;

	localparam int IDLE_PCT       = 12;
	localparam int PHASE_ITEMS    = 35;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic               hit_valid;
		logic [PRIME_W-1:0] hit_prime;
		logic [HPOS_W-1:0]  hit_pos;
		logic [POS_W-1:0]   next_pos;
		logic               odd_exception;
		logic               hit_overflow;
		logic               batch_done;
		logic               last;
	} hit_rec_t;

	typedef struct packed {
		logic [OT_W-1:0]    ot;
		logic [STEP_W-1:0]  s0;
		logic [STEP_W-1:0]  s1;
		logic [POS_W-1:0]   pos;
		logic [PRIME_W-1:0] prime;
		logic               eob;
		logic               typed;
		logic [POS_W-1:0]   t_next;
		logic               t_exc;
		logic               t_ovf;
	} stim_row_t;

	// ot, first step, second step, start, prime, eob, typed, next_pos, exc, ovf
	localparam stim_row_t DIRECTED_ROWS [19] = '{
		// zero steps never leave the region: cap at MAX_HITS
		'{OT_INPUT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0,
			1'b1, 32'hFFFF_0000, 1'b0, 1'b1},
		'{OT_INPUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
			1'b1, 32'hFFFE_FFFF, 1'b0, 1'b0},
		// last position of the region, one hit then out
		'{OT_INPUT, 32'h0000_0001, 32'h0000_0001, 32'h0000_FFFF, 16'h0001, 1'b0,
			1'b1, 32'h0000_0000, 1'b0, 1'b0},
		'{OT_INPUT, 32'h0000_1234, 32'h0000_5678, 32'h0001_0000, 16'h8000, 1'b1,
			1'b1, 32'h0000_0000, 1'b0, 1'b0},
		// position wraps through 2^32
		'{OT_INPUT, 32'hFFFF_8000, 32'hFFFF_8000, 32'h0000_8000, 16'h0102, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		'{OT_INPUT, 32'h0000_0345, 32'h0000_2F00, 32'h0000_0100, 16'h0203, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		'{OT_INPUT, 32'h0000_1001, 32'h0000_0FFE, 32'h0000_0000, 16'h0304, 1'b1,
			1'b0, 32'h0, 1'b0, 1'b0},
		// first step matches the oddness pattern
		'{OT_TYPE1, 32'h0000_0201, 32'h0000_1234, 32'h0000_0000, 16'h0405, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		// second step matches
		'{OT_TYPE1, 32'h0000_0002, 32'h0000_1003, 32'h0000_0000, 16'h0506, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		// exceptional start, equal i parts
		'{OT_TYPE1, 32'h0000_0010, 32'h0000_2010, 32'h0000_0000, 16'h0607, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		// exceptional start, i parts differ
		'{OT_TYPE1, 32'h0000_0010, 32'h0000_0020, 32'h0000_0000, 16'h0708, 1'b1,
			1'b0, 32'h0, 1'b0, 1'b0},
		'{OT_TYPE1, 32'h0000_0020, 32'h0000_0010, 32'h0000_0000, 16'h0809, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		// exceptional start without the flag
		'{OT_TYPE2, 32'h0000_0011, 32'h0000_2011, 32'h0000_0000, 16'h090A, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		'{OT_TYPE2, 32'h0000_1002, 32'h0000_0007, 32'h0000_0000, 16'h0A0B, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		'{OT_TYPE2, 32'h0000_0003, 32'h0000_0002, 32'h0000_0000, 16'h0B0C, 1'b1,
			1'b0, 32'h0, 1'b0, 1'b0},
		'{OT_TYPE3, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
			1'b1, 32'hFFFF_0000, 1'b1, 1'b1},
		'{OT_TYPE3, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0000, 16'h0C0D, 1'b0,
			1'b1, 32'h7FFE_FFFF, 1'b0, 1'b0},
		'{OT_TYPE3, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0000, 16'h0D0E, 1'b0,
			1'b0, 32'h0, 1'b0, 1'b0},
		// step sum wraps through 2^32
		'{OT_TYPE3, 32'hFFFF_F004, 32'h0000_1002, 32'h0000_0000, 16'h0E0F, 1'b1,
			1'b0, 32'h0, 1'b0, 1'b0}
	};

	localparam logic [OT_W-1:0] PHASE_OT [8] = '{
		OT_INPUT, OT_TYPE1, OT_TYPE2, OT_TYPE3, OT_INPUT, OT_TYPE3, OT_TYPE2, OT_TYPE1
	};

	logic clk = 1'b0;
	logic arst_n;

	lsw_prime_if prime_ch ();
	lsw_hit_if   hit_ch ();
	lsw_cfg_if   cfg_ch ();

	hit_rec_t        expected_hits [$];
	logic [OT_W-1:0] cur_ot;
	bit              calm;
	int              errors;

	lattice_sieve_prime_walk_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.prime_ch (prime_ch),
		.hit_ch   (hit_ch),
		.cfg_ch   (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Derive the start, walk the lattice and queue every hit plus the writeback.
	function automatic void walk_prime(input logic [31:0] s0, input logic [31:0] s1,
		input logic [31:0] start, input logic [15:0] prime, input logic eob,
		input logic [OT_W-1:0] ot);
		logic [31:0] lim_a, lim_b, pos, st, tester, i_part;
		logic        exc, ovf;
		int          n;
		hit_rec_t    r;

		lim_a = NI - (s0 & NI_MASK);
		lim_b = NI - (s1 & NI_MASK);
		exc   = 1'b0;
		ovf   = 1'b0;
		pos   = start;
		n     = 0;
		if (ot != OT_INPUT) begin
			tester = {31'd0, ot[0]} | (ot[1] ? NI : 32'd0);
			if ((s0 & ODD_MASK) == tester) begin
				st = s0;
			end else if ((s1 & ODD_MASK) == (tester ^ NI)) begin
				st = s1;
			end else if ((s0 & NI_MASK) <= (s1 & NI_MASK) && s0 <= s1) begin
				st  = ((s0 & NI_MASK) == (s1 & NI_MASK)) ? s1 - s0 : NI;
				exc = (ot != OT_TYPE2);
			end else begin
				st = s0 + s1;
			end
			// keep the sum at 32 bits before halving
			st  = st + (~tester & NI);
			pos = st >> 1;
		end
		while (pos < REGION) begin
			if (n >= MAX_HITS_DEF) begin
				ovf = 1'b1;
				break;
			end
			r           = '0;
			r.hit_valid = 1'b1;
			r.hit_prime = prime;
			r.hit_pos   = pos[HPOS_W-1:0];
			expected_hits.push_back(r);
			n++;
			i_part = pos & NI_MASK;
			if (i_part < lim_b)
				pos += s0;
			if (i_part >= lim_a)
				pos += s1;
		end
		r               = '0;
		r.hit_prime     = prime;
		r.next_pos      = pos - REGION;
		r.odd_exception = exc;
		r.hit_overflow  = ovf;
		r.batch_done    = eob;
		r.last          = 1'b1;
		expected_hits.push_back(r);
	endfunction

	function automatic logic [31:0] lattice_step();
		return (32'($urandom_range(3)) << (I_BITS_DEF - 1)) | 32'($urandom_range(4095));
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	task automatic send_prime(input logic [31:0] s0, input logic [31:0] s1,
		input logic [31:0] pos, input logic [15:0] prime, input logic eob);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			prime_ch.valid <= 1'b0;
			@(posedge clk);
		end
		prime_ch.valid        <= 1'b1;
		prime_ch.first_step   <= s0;
		prime_ch.second_step  <= s1;
		prime_ch.start_pos    <= pos;
		prime_ch.prime_index  <= prime;
		prime_ch.end_of_batch <= eob;
		do
			@(posedge clk);
		while (!prime_ch.ready);
		walk_prime(s0, s1, pos, prime, eob, cur_ot);
	endtask

	task automatic wait_drained();
		prime_ch.valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_oddness(input logic [OT_W-1:0] value);
		wait_drained();
		cfg_ch.valid        <= 1'b1;
		cfg_ch.oddness_type <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_ot = value;
	endtask

	// result side: random backpressure and checks against the oldest expectation
	initial begin
		hit_rec_t want;

		hit_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && hit_ch.valid && hit_ch.ready) begin
				if (expected_hits.size() == 0) begin
					$error("hit_ch: transaction with nothing expected, prime %0h",
						hit_ch.hit_prime);
					errors++;
				end else begin
					want = expected_hits.pop_front();
					check_field("hit_valid", 32'(want.hit_valid), 32'(hit_ch.hit_valid));
					check_field("hit_prime", 32'(want.hit_prime), 32'(hit_ch.hit_prime));
					check_field("hit_pos", 32'(want.hit_pos), 32'(hit_ch.hit_pos));
					check_field("next_pos", want.next_pos, hit_ch.next_pos);
					check_field("odd_exception", 32'(want.odd_exception),
						32'(hit_ch.odd_exception));
					check_field("hit_overflow", 32'(want.hit_overflow),
						32'(hit_ch.hit_overflow));
					check_field("batch_done", 32'(want.batch_done), 32'(hit_ch.batch_done));
					check_field("last", 32'(want.last), 32'(hit_ch.last));
				end
			end
			hit_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// abort when no channel moves a transaction for too long
	initial begin
		int quiet;

		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (prime_ch.valid && prime_ch.ready) ||
				(hit_ch.valid && hit_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int          k, phase, pick;
		logic [31:0] s0, s1, pos;
		logic [15:0] prime;
		logic        eob;
		stim_row_t   row;
		hit_rec_t    fin;

		errors                = 0;
		calm                  = 1'b0;
		cur_ot                = OT_INPUT;
		arst_n                = 1'b0;
		prime_ch.valid        = 1'b0;
		prime_ch.first_step   = '0;
		prime_ch.second_step  = '0;
		prime_ch.start_pos    = '0;
		prime_ch.prime_index  = '0;
		prime_ch.end_of_batch = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.oddness_type   = OT_INPUT;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_oddness(OT_INPUT);
		for (k = 0; k < $size(DIRECTED_ROWS); k++) begin
			row = DIRECTED_ROWS[k];
			if (row.ot != cur_ot)
				write_oddness(row.ot);
			send_prime(row.s0, row.s1, row.pos, row.prime, row.eob);
			if (row.typed) begin
				// the writeback of this prime is the newest expectation
				fin               = expected_hits.pop_back();
				fin.next_pos      = row.t_next;
				fin.odd_exception = row.t_exc;
				fin.hit_overflow  = row.t_ovf;
				expected_hits.push_back(fin);
			end
		end

		for (phase = 0; phase < $size(PHASE_OT); phase++) begin
			write_oddness(PHASE_OT[phase]);
			calm = (phase == 4);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				prime = 16'($urandom_range(65535));
				eob   = ($urandom_range(7) == 0);
				pick  = $urandom_range(99);
				if (pick < 60) begin
					s0  = lattice_step();
					s1  = lattice_step();
					pos = $urandom_range(65535);
				end else if (pick < 85) begin
					s0  = $urandom();
					s1  = $urandom();
					pos = $urandom();
				end else begin
					s0  = lattice_step();
					s1  = lattice_step();
					pos = $urandom_range(65535);
					case ($urandom_range(4))
						0: begin
							s0 = '0;
							s1 = '0;
						end
						1: begin
							s0 = $urandom();
							s1 = s0;
						end
						2: begin
							pos = REGION - 32'($urandom_range(2));
						end
						3: begin
							s0 = 32'hFFFF_0000 | 32'($urandom_range(65535));
							s1 = 32'hFFFF_F000 | 32'($urandom_range(4095));
						end
						default: begin
							pos = 32'hFFFF_FFFF - 32'($urandom_range(3));
						end
					endcase
				end
				send_prime(s0, s1, pos, prime, eob);
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
